### src/eon_pkg.sv
`default_nettype none
package eon_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 1'b1;

  localparam logic signed [15:0] THRESH_RESET = 16'sd384;
  localparam logic [12:0]        WIDTH_RESET  = 13'd512;

  typedef struct packed {
    logic signed [15:0] fit_score;
    logic [15:0]        major_axis;
    logic [15:0]        axis_ratio;
    logic [23:0]        pixel_index;
    logic               last_record;
  } fit_rec_t;

  typedef struct packed {
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic [15:0]        out_major;
    logic [15:0]        out_minor;
    logic signed [15:0] out_score;
    logic               none_found;
    logic               dropped;
    logic               final_result;
  } ellipse_res_t;

endpackage
`default_nettype wire

### src/eon_div.sv
`default_nettype none
module eon_div import eon_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [23:0] dividend,
  input  wire logic [12:0] divisor,
  output logic             busy,
  output logic [23:0]      quotient,
  output logic [12:0]      remainder
);

  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [12:0] dvs_r, dvs_nxt;
  logic [13:0] rem_sh;

  // one quotient bit per cycle, restoring
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[23]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      quo_nxt  = dividend;
      rem_nxt  = 13'd0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = 13'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[22:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[12:0];
        quo_nxt = {quo_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### src/eon_mul.sv
`default_nettype none
module eon_mul import eon_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic [63:0]      prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, op_a} * {32'd0, op_b};
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

### src/ellipse_overlap_nms.sv
// Loading: one record per cycle while idle; a frame ends on the record flagged last.
// Selection: each round scans the scores in the candidate memory, runs the
//   bit-serial divider, derives the minor radius, checks overlap against the
//   kept ellipses through the shared 32x32 multiplier, then accepts or rejects
//   the best candidate and advances.
// Results leave one at a time from the kept memory, each read and then loaded; input stalls meanwhile.
// Synchronous active-low reset clears control and counters; registers reload.
`default_nettype none
module ellipse_overlap_nms import eon_pkg::*; #(
  parameter int MAX_CANDIDATES = 256,
  parameter int MAX_ACCEPTED   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fit_rec_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ellipse_res_t              out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int CAW = $clog2(MAX_CANDIDATES);
  localparam int CNW = $clog2(MAX_CANDIDATES + 1);
  localparam int KAW = (MAX_ACCEPTED > 1) ? $clog2(MAX_ACCEPTED) : 1;
  localparam int KNW = $clog2(MAX_ACCEPTED + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN_RD  = 4'd1;
  localparam logic [3:0] ST_SCAN_CMP = 4'd2;
  localparam logic [3:0] ST_DIV_GO   = 4'd3;
  localparam logic [3:0] ST_DIV_WAIT = 4'd4;
  localparam logic [3:0] ST_MIN_MUL  = 4'd5;
  localparam logic [3:0] ST_MIN_GET  = 4'd6;
  localparam logic [3:0] ST_CHK_RD   = 4'd7;
  localparam logic [3:0] ST_CHK_MUL  = 4'd8;
  localparam logic [3:0] ST_CHK_CMP  = 4'd9;
  localparam logic [3:0] ST_ACCEPT   = 4'd10;
  localparam logic [3:0] ST_ROUND    = 4'd11;
  localparam logic [3:0] ST_EMIT_RD  = 4'd12;
  localparam logic [3:0] ST_EMIT_LD  = 4'd13;
  localparam logic [3:0] ST_EMIT_NONE = 4'd14;

  // memories
  logic [39:0] cand_key_mem   [MAX_CANDIDATES];
  logic [31:0] cand_shape_mem [MAX_CANDIDATES];
  logic        cand_vis_mem   [MAX_CANDIDATES];
  logic [71:0] kept_mem       [MAX_ACCEPTED];
  logic [39:0] key_q;
  logic [31:0] shape_q;
  logic        vis_q;
  logic [71:0] kept_q;

  logic [3:0]  state_r, state_nxt;
  logic signed [15:0] thr_r;
  logic [12:0] width_r;
  logic [CNW-1:0] cand_cnt_r, cand_cnt_nxt;
  logic [KNW-1:0] kept_cnt_r, kept_cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [CNW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [KNW-1:0] k_r, k_nxt;
  logic        found_r, found_nxt;
  logic [CAW-1:0] best_r, best_nxt;
  logic signed [15:0] best_score_r, best_score_nxt;
  logic [23:0] best_idx_r, best_idx_nxt;
  logic [15:0] best_major_r, best_major_nxt;
  logic [15:0] best_ratio_r, best_ratio_nxt;
  logic [11:0] px_r, px_nxt, py_r, py_nxt;
  logic [15:0] minor_r, minor_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [23:0] dx2_r, dx2_nxt, dy2_r, dy2_nxt;
  logic [31:0] m2_r, m2_nxt, bigm2_r, bigm2_nxt;
  logic [55:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic [63:0] p3_r, p3_nxt;
  logic        out_valid_r, out_valid_nxt;
  ellipse_res_t out_data_r, out_data_nxt;

  logic        cand_we, vis_we, vis_wd, kept_we;
  logic [CAW-1:0] cand_waddr, vis_waddr;
  logic        in_acc, keep_rec;
  logic        div_start, div_busy;
  logic [23:0] div_quo;
  logic [12:0] div_rem;
  logic [12:0] width_eff;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [11:0] kx, ky, dx, dy;
  logic [15:0] km, kmin;
  logic [56:0] lhs_s;
  logic [70:0] lhs, rhs;
  logic        hit;

  assign in_acc   = in_valid && !in_stall;
  assign keep_rec = $signed(in_data.fit_score) > thr_r;
  assign width_eff = (width_r == 13'd0) ? 13'd1 : width_r;

  assign kx   = kept_q[71:60];
  assign ky   = kept_q[59:48];
  assign km   = kept_q[47:32];
  assign kmin = kept_q[31:16];
  assign dx   = (kx > px_r) ? kx - px_r : px_r - kx;
  assign dy   = (ky > py_r) ? ky - py_r : py_r - ky;
  assign lhs_s = {1'b0, t1_r} + {1'b0, t2_r};
  assign lhs   = {lhs_s, 14'd0};
  assign rhs   = {3'd0, ({4'd0, p3_r} << 3) + {4'd0, p3_r}};
  assign hit   = lhs < rhs;

  eon_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (best_idx_r),
    .divisor   (width_eff),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  eon_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (state_r == ST_MIN_MUL) begin
      mul_a = {16'd0, best_major_r};
      mul_b = {16'd0, best_ratio_r};
    end else if (state_r == ST_CHK_MUL) begin
      case (step_r)
        3'd0: begin mul_a = {20'd0, dx}; mul_b = {20'd0, dx}; end
        3'd1: begin mul_a = {20'd0, dy}; mul_b = {20'd0, dy}; end
        3'd2: begin mul_a = {16'd0, kmin}; mul_b = {16'd0, kmin}; end
        3'd3: begin mul_a = {16'd0, km}; mul_b = {16'd0, km}; end
        3'd4: begin mul_a = {8'd0, dx2_r}; mul_b = m2_r; end
        3'd5: begin mul_a = {8'd0, dy2_r}; mul_b = bigm2_r; end
        3'd6: begin mul_a = bigm2_r; mul_b = m2_r; end
        default: begin mul_a = 32'd0; mul_b = 32'd0; end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cand_cnt_nxt   = cand_cnt_r;
    kept_cnt_nxt   = kept_cnt_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_score_nxt = best_score_r;
    best_idx_nxt   = best_idx_r;
    best_major_nxt = best_major_r;
    best_ratio_nxt = best_ratio_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    minor_nxt      = minor_r;
    step_nxt       = step_r;
    dx2_nxt        = dx2_r;
    dy2_nxt        = dy2_r;
    m2_nxt         = m2_r;
    bigm2_nxt      = bigm2_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    p3_nxt         = p3_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    cand_we        = 1'b0;
    cand_waddr     = cand_cnt_r[CAW-1:0];
    vis_we         = 1'b0;
    vis_waddr      = cand_cnt_r[CAW-1:0];
    vis_wd         = 1'b0;
    kept_we        = 1'b0;
    div_start      = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (keep_rec) begin
            if (cand_cnt_r < CNW'(MAX_CANDIDATES)) begin
              cand_we      = 1'b1;
              vis_we       = 1'b1;
              cand_cnt_nxt = cand_cnt_r + CNW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_data.last_record) begin
            i_nxt     = '0;
            j_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = (cand_cnt_nxt == '0) ? ST_EMIT_NONE : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        // strict compare keeps the earliest of equal scores
        if (!vis_q && (!found_r || $signed(key_q[39:24]) > best_score_r)) begin
          found_nxt      = 1'b1;
          best_nxt       = j_r[CAW-1:0];
          best_score_nxt = key_q[39:24];
          best_idx_nxt   = key_q[23:0];
          best_major_nxt = shape_q[31:16];
          best_ratio_nxt = shape_q[15:0];
        end
        if (j_r + CNW'(1) == cand_cnt_r) begin
          state_nxt = ST_DIV_GO;
        end else begin
          j_nxt     = j_r + CNW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_DIV_GO: begin
        vis_we    = 1'b1;
        vis_waddr = best_r;
        vis_wd    = 1'b1;
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          px_nxt    = div_rem[11:0];
          py_nxt    = div_quo[11:0];
          state_nxt = ST_MIN_MUL;
        end
      end
      ST_MIN_MUL: state_nxt = ST_MIN_GET;
      ST_MIN_GET: begin
        minor_nxt = mul_p[31:16];
        k_nxt     = '0;
        state_nxt = (kept_cnt_r == '0) ? ST_ACCEPT : ST_CHK_RD;
      end
      ST_CHK_RD: begin
        step_nxt  = 3'd0;
        state_nxt = ST_CHK_MUL;
      end
      ST_CHK_MUL: begin
        case (step_r)
          3'd1: dx2_nxt   = mul_p[23:0];
          3'd2: dy2_nxt   = mul_p[23:0];
          3'd3: m2_nxt    = mul_p[31:0];
          3'd4: bigm2_nxt = mul_p[31:0];
          3'd5: t1_nxt    = mul_p[55:0];
          3'd6: t2_nxt    = mul_p[55:0];
          3'd7: p3_nxt    = mul_p;
          default: ;
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) state_nxt = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (hit) begin
          state_nxt = ST_ROUND;
        end else if (k_r + KNW'(1) == kept_cnt_r) begin
          state_nxt = ST_ACCEPT;
        end else begin
          k_nxt     = k_r + KNW'(1);
          state_nxt = ST_CHK_RD;
        end
      end
      ST_ACCEPT: begin
        if (kept_cnt_r >= KNW'(MAX_ACCEPTED)) begin
          ovf_nxt = 1'b1;
        end else begin
          kept_we      = 1'b1;
          kept_cnt_nxt = kept_cnt_r + KNW'(1);
        end
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (i_r + CNW'(1) == cand_cnt_r) begin
          k_nxt     = '0;
          state_nxt = (kept_cnt_r == '0) ? ST_EMIT_NONE : ST_EMIT_RD;
        end else begin
          i_nxt     = i_r + CNW'(1);
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (!out_valid_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.center_x     = kx;
          out_data_nxt.center_y     = ky;
          out_data_nxt.out_major    = km;
          out_data_nxt.out_minor    = kmin;
          out_data_nxt.out_score    = kept_q[15:0];
          out_data_nxt.none_found   = 1'b0;
          out_data_nxt.dropped      = ovf_r;
          out_data_nxt.final_result = (k_r + KNW'(1) == kept_cnt_r);
          if (k_r + KNW'(1) == kept_cnt_r) begin
            cand_cnt_nxt = '0;
            kept_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            k_nxt     = k_r + KNW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_NONE: begin
        if (!out_valid_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.none_found   = 1'b1;
          out_data_nxt.dropped      = ovf_r;
          out_data_nxt.final_result = 1'b1;
          cand_cnt_nxt = '0;
          kept_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_key_mem[cand_waddr]   <= {in_data.fit_score, in_data.pixel_index};
      cand_shape_mem[cand_waddr] <= {in_data.major_axis, in_data.axis_ratio};
    end
    if (vis_we) cand_vis_mem[vis_waddr] <= vis_wd;
    key_q   <= cand_key_mem[j_r[CAW-1:0]];
    shape_q <= cand_shape_mem[j_r[CAW-1:0]];
    vis_q   <= cand_vis_mem[j_r[CAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (kept_we) begin
      kept_mem[kept_cnt_r[KAW-1:0]] <= {px_r, py_r, best_major_r, minor_r, best_score_r};
    end
    kept_q <= kept_mem[k_r[KAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESH_RESET;
      width_r     <= WIDTH_RESET;
      cand_cnt_r  <= '0;
      kept_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cand_cnt_r  <= cand_cnt_nxt;
      kept_cnt_r  <= kept_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCORE_THRESHOLD) thr_r <= cfg_data;
        else if (cfg_index == REG_IMAGE_WIDTH) width_r <= cfg_data[12:0];
      end
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_score_r <= best_score_nxt;
    best_idx_r   <= best_idx_nxt;
    best_major_r <= best_major_nxt;
    best_ratio_r <= best_ratio_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    minor_r      <= minor_nxt;
    step_r       <= step_nxt;
    dx2_r        <= dx2_nxt;
    dy2_r        <= dy2_nxt;
    m2_r         <= m2_nxt;
    bigm2_r      <= bigm2_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    p3_r         <= p3_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= KNW'(MAX_ACCEPTED)) else $error("kept count beyond capacity");
  a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cand_cnt_r <= CNW'(MAX_CANDIDATES)) else $error("candidate count beyond capacity");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.final_result && $rose(out_valid_r)) |-> kept_cnt_r == '0)
    else $error("frame not cleared after final result");

endmodule
`default_nettype wire
